/* src/cbez_pkg.sv */
// ---------------------------------------------------------------------------
// cbez_pkg
// Shared types, constants and arithmetic helpers for the cubic curve evaluator.
// ---------------------------------------------------------------------------
package cbez_pkg;

	localparam int COORD_W  = 32;
	localparam int T_FRAC   = 16;
	localparam int T_W      = T_FRAC + 1;
	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = 5;
	localparam int PROD_W   = COORD_W + T_W + 2;
	localparam int T_HALF   = 1 << (T_FRAC - 1);

	localparam logic [1:0] OP_POINT   = 2'd0;
	localparam logic [1:0] OP_TANGENT = 2'd1;
	localparam logic [1:0] OP_SPLIT   = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [2:0] IDX_LAST = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   diff_t;
	typedef logic        [T_W-1:0]     tpar_t;

	localparam tpar_t T_ONE = tpar_t'(1) << T_FRAC;

	typedef struct packed {
		logic [1:0] opcode;
		tpar_t      param_t;
	} in_item_t;

	typedef struct packed {
		coord_t     out_x;
		coord_t     out_y;
		logic [2:0] point_index;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		logic          split;
		pt_t [7:0]     pts;
	} bundle_t;

	function automatic diff_t lerp_diff(coord_t a, coord_t b);
		return {b[COORD_W-1], b} - {a[COORD_W-1], a};
	endfunction

	// a + round_half_up(d * t / 2^T_FRAC)
	function automatic coord_t lerp_fin(coord_t a, diff_t d, tpar_t t);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(d) * PROD_W'($signed({1'b0, t}));
		p = p + PROD_W'(T_HALF);
		p = p >>> T_FRAC;
		return a + $signed(p[COORD_W-1:0]);
	endfunction

	function automatic coord_t sat_gain3(diff_t d);
		logic signed [COORD_W+2:0] g;
		g = {{2{d[COORD_W]}}, d} + {d[COORD_W], d, 1'b0};
		if (g[COORD_W+2:COORD_W-1] == '0 || g[COORD_W+2:COORD_W-1] == '1) begin
			return g[COORD_W-1:0];
		end
		return g[COORD_W+2] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

/* src/cbez_front.sv */
// ---------------------------------------------------------------------------
// cbez_front
// Accepts items, drops unused opcodes, clamps t and runs the interpolation
// pyramid: three levels, each a difference stage then a multiply stage.
// ---------------------------------------------------------------------------
module cbez_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cbez_pkg::coord_t    cfg [cbez_pkg::NUM_REGS],
	input  logic                push,
	input  cbez_pkg::in_item_t  push_data,
	output logic                full,
	output logic                q_push,
	output cbez_pkg::bundle_t   q_data,
	input  logic                q_full
);
	import cbez_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [1:0] op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7;
	tpar_t t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;

	diff_t  d1_s2 [2][3];
	coord_t l1_s3 [2][3];
	diff_t  d2_s4 [2][2];
	coord_t l1_s4 [2][3];
	coord_t l2_s5 [2][2];
	coord_t ab_s5 [2], cd_s5 [2];
	diff_t  d3_s6 [2];
	coord_t l2_s6 [2][2];
	coord_t ab_s6 [2], cd_s6 [2];
	coord_t abcd_s7 [2], der_s7 [2], ab_s7 [2], cd_s7 [2];
	coord_t l2_s7 [2][2];

	assign adv    = !(v_s7 && q_full);
	assign full   = !adv;
	assign q_push = v_s7 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push && (push_data.opcode != OP_NONE);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= push_data.opcode;
			t_s1  <= (push_data.param_t > T_ONE) ? T_ONE : push_data.param_t;
			op_s2 <= op_s1;
			t_s2  <= t_s1;
			op_s3 <= op_s2;
			t_s3  <= t_s2;
			op_s4 <= op_s3;
			t_s4  <= t_s3;
			op_s5 <= op_s4;
			t_s5  <= t_s4;
			op_s6 <= op_s5;
			t_s6  <= t_s5;
			op_s7 <= op_s6;
			for (int c = 0; c < 2; c++) begin
				for (int j = 0; j < 3; j++) begin
					d1_s2[c][j] <= lerp_diff(cfg[2*j+c], cfg[2*j+2+c]);
					l1_s3[c][j] <= lerp_fin(cfg[2*j+c], d1_s2[c][j], t_s2);
					l1_s4[c][j] <= l1_s3[c][j];
				end
				for (int j = 0; j < 2; j++) begin
					d2_s4[c][j] <= lerp_diff(l1_s3[c][j], l1_s3[c][j+1]);
					l2_s5[c][j] <= lerp_fin(l1_s4[c][j], d2_s4[c][j], t_s4);
					l2_s6[c][j] <= l2_s5[c][j];
					l2_s7[c][j] <= l2_s6[c][j];
				end
				ab_s5[c]   <= l1_s4[c][0];
				cd_s5[c]   <= l1_s4[c][2];
				d3_s6[c]   <= lerp_diff(l2_s5[c][0], l2_s5[c][1]);
				ab_s6[c]   <= ab_s5[c];
				cd_s6[c]   <= cd_s5[c];
				abcd_s7[c] <= lerp_fin(l2_s6[c][0], d3_s6[c], t_s6);
				der_s7[c]  <= sat_gain3(d3_s6[c]);
				ab_s7[c]   <= ab_s6[c];
				cd_s7[c]   <= cd_s6[c];
			end
		end
	end

	always_comb begin
		q_data.split    = (op_s7 == OP_SPLIT);
		q_data.pts[0].x = cfg[0];
		q_data.pts[0].y = cfg[1];
		q_data.pts[1].x = ab_s7[0];
		q_data.pts[1].y = ab_s7[1];
		q_data.pts[2].x = l2_s7[0][0];
		q_data.pts[2].y = l2_s7[1][0];
		q_data.pts[3].x = abcd_s7[0];
		q_data.pts[3].y = abcd_s7[1];
		q_data.pts[4].x = abcd_s7[0];
		q_data.pts[4].y = abcd_s7[1];
		q_data.pts[5].x = l2_s7[0][1];
		q_data.pts[5].y = l2_s7[1][1];
		q_data.pts[6].x = cd_s7[0];
		q_data.pts[6].y = cd_s7[1];
		q_data.pts[7].x = cfg[6];
		q_data.pts[7].y = cfg[7];
		case (op_s7)
			OP_POINT: begin
				q_data.pts[0].x = abcd_s7[0];
				q_data.pts[0].y = abcd_s7[1];
			end
			OP_TANGENT: begin
				q_data.pts[0].x = der_s7[0];
				q_data.pts[0].y = der_s7[1];
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/cbez_queue.sv */
// ---------------------------------------------------------------------------
// cbez_queue
// Two-entry queue of finished result sets between front and back.
// ---------------------------------------------------------------------------
module cbez_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  cbez_pkg::bundle_t  wr_data,
	output logic               q_full,
	input  logic               rd,
	output cbez_pkg::bundle_t  rd_data,
	output logic               q_empty
);
	import cbez_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	bundle_t          mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign q_full  = (cnt_q == (PW+1)'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

/* src/cbez_back.sv */
// ---------------------------------------------------------------------------
// cbez_back
// Walks the queued result set one point per beat into the output register.
// ---------------------------------------------------------------------------
module cbez_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cbez_pkg::bundle_t   head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output cbez_pkg::out_item_t pop_data
);
	import cbez_pkg::*;

	logic       ov_q;
	logic [2:0] idx_q;
	out_item_t  out_q;
	logic       load;
	logic       last;

	assign load     = !q_empty && (!ov_q || pop);
	assign last     = !head.split || (idx_q == IDX_LAST);
	assign q_pop    = load && last;
	assign empty    = !ov_q;
	assign pop_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_x       <= head.pts[idx_q].x;
			out_q.out_y       <= head.pts[idx_q].y;
			out_q.point_index <= idx_q;
			out_q.last_result <= last;
		end
	end

endmodule

/* src/cubic_bezier_evaluator.sv */
// ---------------------------------------------------------------------------
// cubic_bezier_evaluator
// Point, tangent and split of a 2D cubic curve held in eight APB registers.
//
//   port group        dir  beat moves on
//   push/push_data    in   push && !full
//   pop/pop_data      out  pop && !empty
//   APB               in   psel && penable && pwrite (write), reads any time
//
// Point and tangent: one item per cycle while full is low.
// Split: eight result beats per item; the back end pops one point per cycle while pop keeps up.
// Front pipeline is 7 stages (input register, then three interpolation levels
// of two stages each); a two-entry queue sits between it and the output register.
// A stalled output backs up the queue, then freezes the front (full high).
// Reset clears all handshake state and the curve registers to zero.
// ---------------------------------------------------------------------------
module cubic_bezier_evaluator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  cbez_pkg::in_item_t        push_data,
	output logic                      full,
	output logic                      empty,
	input  logic                      pop,
	output cbez_pkg::out_item_t       pop_data,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cbez_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import cbez_pkg::*;

	coord_t  cfg_q [NUM_REGS];
	logic    cfg_wr;
	logic    q_push, q_full, q_pop, q_empty;
	bundle_t q_wdata, q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = cfg_q[paddr[ADDR_W-1:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			cfg_q[paddr[ADDR_W-1:2]] <= pwdata;
		end
	end

	cbez_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	cbez_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_data (q_rdata),
		.q_empty (q_empty)
	);

	cbez_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.pop_data (pop_data)
	);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic curve evaluator. Curves are loaded over
// APB (each write read back), then point, tangent, split and unused-opcode
// requests are pushed with random gaps on both queue sides. Every popped beat
// is checked field by field against an in-bench de Casteljau predictor.
// One phase holds the pop side off long enough to back the block up.
// ---------------------------------------------------------------------------
module tb_top;
	import cbez_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int STALL_CYCLES = 300;
	localparam int SETTLE       = 32;
	localparam int TANGENT_GAIN = 3;

	localparam int REG_START_X = 0;
	localparam int REG_START_Y = 1;
	localparam int REG_CTRL1_X = 2;
	localparam int REG_CTRL1_Y = 3;
	localparam int REG_CTRL2_X = 4;
	localparam int REG_CTRL2_Y = 5;
	localparam int REG_END_X   = 6;
	localparam int REG_END_Y   = 7;

	localparam coord_t CRD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t CRD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	in_item_t          push_data = '0;
	logic              full;
	logic              empty;
	logic              pop     = 1'b0;
	out_item_t         pop_data;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	in_item_t  t_requests [$];
	out_item_t curve_results_due [$];
	coord_t    curve_reg [NUM_REGS];

	logic in_beat  = 1'b0;
	logic out_beat = 1'b0;
	bit   smooth   = 1'b0;
	int   push_gap = 0;
	int   pop_gap  = 0;
	int   stall_req = 0;
	int   stall_ack = 0;
	int   stall_left = 0;
	int   idle_cyc = 0;
	int   err_cnt  = 0;
	int   n_beats  = 0;
	int   n_by_op [4] = '{0, 0, 0, 0};

	cubic_bezier_evaluator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// a + round_half_up((b - a) * t / 2^T_FRAC)
	function automatic longint lerp_q16(longint a, longint b, longint t);
		longint p;
		p = (b - a) * t + longint'(T_HALF);
		return a + (p >>> T_FRAC);
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > longint'(CRD_MAX)) return CRD_MAX;
		if (v < longint'(CRD_MIN)) return CRD_MIN;
		return coord_t'(v);
	endfunction

	function automatic void queue_result(longint x, longint y, int idx, bit last);
		out_item_t r;
		r.out_x       = coord_t'(x);
		r.out_y       = coord_t'(y);
		r.point_index = 3'(idx);
		r.last_result = last;
		curve_results_due.push_back(r);
	endfunction

	function automatic void de_casteljau_eval(in_item_t req);
		longint t;
		longint bc;
		longint p [2][4];
		longint s [2][8];
		if (req.opcode == OP_NONE) return;
		t = (req.param_t > T_ONE) ? longint'(T_ONE) : longint'(req.param_t);
		for (int c = 0; c < 2; c++) begin
			for (int k = 0; k < 4; k++) p[c][k] = curve_reg[2*k + c];
			// split order: start ab abc abcd | abcd bcd cd end
			s[c][0] = p[c][0];
			s[c][1] = lerp_q16(p[c][0], p[c][1], t);
			bc      = lerp_q16(p[c][1], p[c][2], t);
			s[c][6] = lerp_q16(p[c][2], p[c][3], t);
			s[c][2] = lerp_q16(s[c][1], bc, t);
			s[c][5] = lerp_q16(bc, s[c][6], t);
			s[c][3] = lerp_q16(s[c][2], s[c][5], t);
			s[c][4] = s[c][3];
			s[c][7] = p[c][3];
		end
		case (req.opcode)
			OP_POINT: begin
				queue_result(s[0][3], s[1][3], 0, 1'b1);
			end
			OP_TANGENT: begin
				queue_result(clamp_coord(TANGENT_GAIN * (s[0][5] - s[0][2])),
					clamp_coord(TANGENT_GAIN * (s[1][5] - s[1][2])), 0, 1'b1);
			end
			OP_SPLIT: begin
				for (int k = 0; k < 8; k++)
					queue_result(s[0][k], s[1][k], k, k == IDX_LAST);
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(string what, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	function automatic in_item_t make_request(logic [1:0] op, tpar_t t);
		in_item_t r;
		r.opcode  = op;
		r.param_t = t;
		return r;
	endfunction

	function automatic in_item_t random_request();
		int   sel;
		tpar_t t;
		logic [1:0] op;
		sel = $urandom_range(0, 99);
		op  = (sel < 38) ? OP_POINT : (sel < 66) ? OP_TANGENT : (sel < 92) ? OP_SPLIT : OP_NONE;
		case ($urandom_range(0, 19))
			0:       t = '0;
			1:       t = T_ONE;
			2:       t = tpar_t'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
			3:       t = tpar_t'(1);
			4:       t = T_ONE - 1;
			default: t = tpar_t'($urandom_range(0, T_ONE));
		endcase
		return make_request(op, t);
	endfunction

	function automatic coord_t random_coord(int kind);
		int k;
		k = (kind == 3) ? $urandom_range(0, 2) : kind;
		case (k)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 32'h0020_0000)) - coord_t'(32'h0010_0000);
			default: begin
				case ($urandom_range(0, 5))
					0: return CRD_MIN;
					1: return CRD_MAX;
					2: return '0;
					3: return '1;
					4: return coord_t'(1);
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// APB write, then read back the same register
	task automatic csr_write(int idx, coord_t val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'(idx * 4);
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		curve_reg[idx] = val;
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", val, $signed(prdata));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic load_curve(int kind);
		for (int i = 0; i < NUM_REGS; i++) csr_write(i, random_coord(kind));
	endtask

	task automatic issue_requests(int n);
		int n_done;
		in_item_t req;
		n_done = 0;
		while (n_done < n) begin
			req = random_request();
			n_done++;
			t_requests.push_back(req);
		end
	endtask

	task automatic drain();
		while (t_requests.size() != 0 || push || curve_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// push side
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || in_beat) begin
			if (push_gap != 0) begin
				push     <= 1'b0;
				push_gap <= push_gap - 1;
			end else if (t_requests.size() != 0) begin
				push      <= 1'b1;
				push_data <= t_requests.pop_front();
				push_gap  <= smooth ? 0 : $urandom_range(0, 3);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// pop side
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			pop        <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_ack != stall_req) begin
			pop        <= 1'b0;
			stall_ack  <= stall_req;
			stall_left <= STALL_CYCLES;
		end else if (!pop || out_beat) begin
			if (pop_gap != 0) begin
				pop     <= 1'b0;
				pop_gap <= pop_gap - 1;
			end else begin
				pop     <= 1'b1;
				pop_gap <= smooth ? 0 : $urandom_range(0, 3);
			end
		end
	end

	// beat monitor and checker
	always @(posedge clk) begin
		out_item_t want;
		in_beat  <= push && !full;
		out_beat <= pop && !empty;
		if (arst_n) begin
			if (push && !full) begin
				n_by_op[push_data.opcode]++;
				de_casteljau_eval(push_data);
			end
			if (pop && !empty) begin
				n_beats++;
				if (curve_results_due.size() == 0) begin
					err_cnt++;
					$display("%0t ns: unexpected beat, expected none, actual x=%0d y=%0d idx=%0d last=%0d",
						$time, pop_data.out_x, pop_data.out_y, pop_data.point_index,
						pop_data.last_result);
				end else begin
					want = curve_results_due.pop_front();
					check_field("out_x", want.out_x, pop_data.out_x);
					check_field("out_y", want.out_y, pop_data.out_y);
					check_field("point_index", want.point_index, pop_data.point_index);
					check_field("last_result", want.last_result, pop_data.last_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("%0t ns: watchdog, no beat for %0d cycles", $time, idle_cyc);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [1:0] ops [4];
		tpar_t      t_grid [4];
		int         n_settings;
		ops    = '{OP_POINT, OP_TANGENT, OP_SPLIT, OP_NONE};
		t_grid = '{tpar_t'(0), T_ONE >> 1, T_ONE, '1};
		n_settings = 1;
		for (int i = 0; i < NUM_REGS; i++) curve_reg[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// curve left at reset values
		for (int i = 0; i < 4; i++) t_requests.push_back(make_request(ops[i], T_ONE >> 1));
		drain();

		// opposite corners, drives the tangent into saturation
		csr_write(REG_START_X, CRD_MIN);
		csr_write(REG_START_Y, CRD_MAX);
		csr_write(REG_CTRL1_X, CRD_MIN);
		csr_write(REG_CTRL1_Y, CRD_MAX);
		csr_write(REG_CTRL2_X, CRD_MAX);
		csr_write(REG_CTRL2_Y, CRD_MIN);
		csr_write(REG_END_X, CRD_MAX);
		csr_write(REG_END_Y, CRD_MIN);
		n_settings++;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				t_requests.push_back(make_request(ops[i], t_grid[j]));
		t_requests.push_back(make_request(OP_POINT, tpar_t'(1)));
		t_requests.push_back(make_request(OP_TANGENT, T_ONE - 1));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			smooth = (ph % 3 == 2);
			load_curve(ph % 4);
			n_settings++;
			if (ph == 5) stall_req++;
			issue_requests(60);
			drain();
		end

		$display("Covered %0d point, %0d tangent, %0d split and %0d ignored requests",
			n_by_op[OP_POINT], n_by_op[OP_TANGENT], n_by_op[OP_SPLIT], n_by_op[OP_NONE]);
		$display("over %0d curve settings, %0d result beats checked", n_settings, n_beats);
		if (err_cnt == 0 && curve_results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* cubic_bezier_evaluator.f */
src/cbez_pkg.sv
src/cbez_front.sv
src/cbez_queue.sv
src/cbez_back.sv
src/cubic_bezier_evaluator.sv
dv/tb_top.sv
